// ===== src/lifetime_slot_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// lifetime slot allocator assertion macros
// Concurrent check helpers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef LIFETIME_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define LIFETIME_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge outside reset
`define LSA_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lsa check failed");

// same-cycle implication
`define LSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsa check failed");

// next-cycle implication
`define LSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsa check failed");

`else

`define LSA_ASSERT_ALWAYS(label, clk, rst, cond)
`define LSA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared widths, constants and types of the lifetime slot allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

  // table depth and arena address width
  localparam int MAX_SLOTS    = 64;
  localparam int ADDRESS_BITS = 40;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int LIVE_W     = 17;
  localparam int COUNT_W    = 32;
  localparam int EB_W       = 5;
  localparam int ALIGN_W    = 4;
  localparam int OUT_ADDR_W = 40;
  localparam int SLOT_OUT_W = 6;

  // byte size and the sums that check against the arena limit
  localparam int SZ_W  = COUNT_W + EB_W;
  localparam int SUM_W = ((ADDRESS_BITS > SZ_W) ? ADDRESS_BITS : SZ_W) + 1;

  // defaults
  localparam int DEFAULT_EB   = 2;
  localparam int UNKNOWN_SIZE = 64;
  localparam int ALIGN_RESET  = 6;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SCAN,
    ST_ALIGN,
    ST_PLACE,
    ST_DONE
  } lsa_state_t;

  // one slot table entry
  typedef struct packed {
    logic [ADDRESS_BITS-1:0] size;
    logic [LIVE_W-1:0]       free_at;
    logic [ADDRESS_BITS-1:0] offset;
  } slot_entry_t;

endpackage

// ===== src/lsa_if.sv =====
// ----------------------------------------------------------------------------
// lsa channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// buffer request channel
interface lsa_in_if import lsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     new_graph;
  logic                     weight_buf;
  logic                     cache_buf;
  logic signed [LIVE_W-1:0] first_op;
  logic signed [LIVE_W-1:0] last_op;
  logic [COUNT_W-1:0]       element_count;
  logic [EB_W-1:0]          element_bytes;

  modport source (
    output valid, new_graph, weight_buf, cache_buf, first_op, last_op,
           element_count, element_bytes,
    input  ready
  );
  modport sink (
    input  valid, new_graph, weight_buf, cache_buf, first_op, last_op,
           element_count, element_bytes,
    output ready
  );
endinterface

// placement result channel
interface lsa_out_if import lsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] offset;
  logic                  reused;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [OUT_ADDR_W-1:0] arena_total;
  logic                  failed;

  modport source (
    output valid, offset, reused, slot_index, arena_total, failed,
    input  ready
  );
  modport sink (
    input  valid, offset, reused, slot_index, arena_total, failed,
    output ready
  );
endinterface

// alignment register write channel
interface lsa_cfg_if import lsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALIGN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/lsa_ram.sv =====
// ----------------------------------------------------------------------------
// lsa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lifetime_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// lifetime_slot_allocator_unit
// First-fit activation buffer allocator over a table of reusable arena slots.
// ----------------------------------------------------------------------------
// Takes one buffer request at a time and places it in the activation arena.
// A request that is skipped (weight, cache or unset lifetime) gives no
// result; its new_graph clear still applies. Any other request goes through
// the size multiply, a first-fit scan that reads the slot table RAM one entry
// per cycle through its single read port, the aligned append (align, then
// place; skipped on a hit, and ended after align when the table is full or
// the alignment overflows), the hand-off of the result to the output register
// and the return to idle. The block takes no request while working; it does
// take one while a finished result still waits on the response side, and a
// second result then waits in the hand-off state until the output register
// is free.
// The slot table has no reset; only entries below the slot count are read.
// ----------------------------------------------------------------------------
`include "lifetime_slot_allocator_unit_assert.svh"

module lifetime_slot_allocator_unit import lsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lsa_cfg_if.sink          cfg,
  lsa_in_if.sink           req,
  lsa_out_if.source        rsp
);

  lsa_state_t state, state_next;

  // configuration
  logic [ALIGN_W-1:0] align_log2;

  // latched request
  logic               new_graph_skip;
  logic [LIVE_W-1:0]  r_start;
  logic [LIVE_W-1:0]  r_end;
  logic [COUNT_W-1:0] r_count;
  logic [EB_W-1:0]    r_eb;
  logic [EB_W-1:0]    eb_eff;
  logic [SZ_W-1:0]    sz;

  // allocator state
  logic [CNT_W-1:0]        slot_count;
  logic [ADDRESS_BITS-1:0] arena_size;

  // scan control
  logic [CNT_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             hit;
  logic             issue;

  // append datapath
  logic [ADDRESS_BITS-1:0] amask;
  logic [SUM_W-1:0]        align_sum;
  logic [SUM_W-1:0]        place_sum;
  logic                    full;
  logic                    ovf_align;
  logic                    ovf_place;
  logic [ADDRESS_BITS-1:0] off_a;

  // result held until the output register is free
  logic [ADDRESS_BITS-1:0] res_offset;
  logic                    res_reused;
  logic [IDX_W-1:0]        res_idx;
  logic [ADDRESS_BITS-1:0] res_top;
  logic                    res_failed;

  // output register
  logic                  out_valid;
  logic [OUT_ADDR_W-1:0] out_offset;
  logic                  out_reused;
  logic [SLOT_OUT_W-1:0] out_idx;
  logic [OUT_ADDR_W-1:0] out_top;
  logic                  out_failed;

  // slot table RAM
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  slot_entry_t            ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [$bits(slot_entry_t)-1:0] ram_rdata;
  slot_entry_t            rd_ent;

  lsa_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  logic req_beat;
  logic skip;
  assign req_beat = req.valid && req.ready;
  assign skip     = req.weight_buf || req.cache_buf ||
                    req.first_op[LIVE_W-1] || req.last_op[LIVE_W-1];
  assign new_graph_skip = req_beat && req.new_graph;

  // scan compare on the entry read in the previous cycle
  assign rd_ent = slot_entry_t'(ram_rdata);
  assign hit    = pend && ($signed(rd_ent.free_at) <= $signed(r_start)) &&
                  (SUM_W'(rd_ent.size) >= SUM_W'(sz));
  assign issue  = scan_idx < slot_count;

  // element size default
  assign eb_eff = (r_eb == '0) ? EB_W'(DEFAULT_EB) : r_eb;

  // append arithmetic
  assign amask     = ~({ADDRESS_BITS{1'b1}} << align_log2);
  assign align_sum = SUM_W'(arena_size) + SUM_W'(amask);
  assign ovf_align = |(align_sum >> ADDRESS_BITS);
  assign full      = slot_count >= CNT_W'(MAX_SLOTS);
  assign place_sum = SUM_W'(off_a) + SUM_W'(sz);
  assign ovf_place = |(place_sum >> ADDRESS_BITS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_beat && !skip) state_next = ST_SIZE;
      end
      ST_SIZE: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) state_next = ST_DONE;
        else if (!issue && !pend) state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (full || ovf_align) state_next = ST_DONE;
        else state_next = ST_PLACE;
      end
      ST_PLACE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: handshake and slot table access
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = rd_ent;
    ram_raddr = scan_idx[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we            = 1'b1;
          ram_waddr         = pend_idx;
          ram_wdata.size    = rd_ent.size;
          ram_wdata.free_at = r_end;
          ram_wdata.offset  = rd_ent.offset;
        end
      end
      ST_PLACE: begin
        if (!ovf_place) begin
          ram_we            = 1'b1;
          ram_waddr         = slot_count[IDX_W-1:0];
          ram_wdata.size    = ADDRESS_BITS'(sz);
          ram_wdata.free_at = r_end;
          ram_wdata.offset  = off_a;
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg.ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      align_log2 <= ALIGN_W'(ALIGN_RESET);
      slot_count <= '0;
      arena_size <= '0;
      pend       <= 1'b0;
      scan_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // register write
      if (cfg.valid && cfg.ready) begin
        align_log2 <= cfg.data;
      end

      // new graph clears the table before the request is looked at
      if (new_graph_skip) begin
        slot_count <= '0;
        arena_size <= '0;
      end

      // scan issue and compare pipeline
      if (state == ST_SIZE) begin
        scan_idx <= '0;
        pend     <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (hit) begin
          pend <= 1'b0;
        end else if (issue) begin
          pend     <= 1'b1;
          scan_idx <= scan_idx + CNT_W'(1);
        end else begin
          pend <= 1'b0;
        end
      end

      // append commits the new slot
      if (state == ST_PLACE && !ovf_place) begin
        slot_count <= slot_count + CNT_W'(1);
        arena_size <= place_sum[ADDRESS_BITS-1:0];
      end

      // output register
      if (state == ST_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // request latch
    if (req_beat) begin
      r_start <= req.first_op;
      r_end   <= req.last_op;
      r_count <= req.element_count;
      r_eb    <= req.element_bytes;
    end

    // byte size
    if (state == ST_SIZE) begin
      sz <= (r_count == '0) ? SZ_W'(UNKNOWN_SIZE) : SZ_W'(r_count) * SZ_W'(eb_eff);
    end

    // index of the entry whose data returns next cycle
    if (state == ST_SCAN && !hit && issue) begin
      pend_idx <= scan_idx[IDX_W-1:0];
    end

    // reuse result
    if (state == ST_SCAN && hit) begin
      res_offset <= rd_ent.offset;
      res_reused <= 1'b1;
      res_idx    <= pend_idx;
      res_top    <= arena_size;
      res_failed <= 1'b0;
    end

    // aligned offset, or failure on a full table or overflow
    if (state == ST_ALIGN) begin
      off_a <= align_sum[ADDRESS_BITS-1:0] & ~amask;
      if (full || ovf_align) begin
        res_offset <= '0;
        res_reused <= 1'b0;
        res_idx    <= '0;
        res_top    <= arena_size;
        res_failed <= 1'b1;
      end
    end

    // append result
    if (state == ST_PLACE) begin
      res_reused <= 1'b0;
      if (ovf_place) begin
        res_offset <= '0;
        res_idx    <= '0;
        res_top    <= arena_size;
        res_failed <= 1'b1;
      end else begin
        res_offset <= off_a;
        res_idx    <= slot_count[IDX_W-1:0];
        res_top    <= place_sum[ADDRESS_BITS-1:0];
        res_failed <= 1'b0;
      end
    end

    // result beat payload
    if (state == ST_DONE && (!out_valid || rsp.ready)) begin
      out_offset <= OUT_ADDR_W'(res_offset);
      out_reused <= res_reused;
      out_idx    <= SLOT_OUT_W'(res_idx);
      out_top    <= OUT_ADDR_W'(res_top);
      out_failed <= res_failed;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.offset      = out_offset;
  assign rsp.reused      = out_reused;
  assign rsp.slot_index  = out_idx;
  assign rsp.arena_total = out_top;
  assign rsp.failed      = out_failed;

  // checks
  `LSA_ASSERT_ALWAYS(a_count_bound, clk, rst, slot_count <= CNT_W'(MAX_SLOTS))
  `LSA_ASSERT_IMPLY(a_scan_bound, clk, rst, state == ST_SCAN, scan_idx <= slot_count)
  `LSA_ASSERT_IMPLY(a_write_state, clk, rst, ram_we, state == ST_SCAN || state == ST_PLACE)
  `LSA_ASSERT_NEXT(a_done_hold, clk, rst, state == ST_DONE && out_valid && !rsp.ready,
                   state == ST_DONE)

endmodule
